>>> rtl/tbe_pkg.sv
// Shared constants, codes and control types of the three-band equalizer.
package tbe_pkg;

   // Default sizes handed to the top level
   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int DELAY_TAPS_DEF   = 3;

   // Fixed number formats
   localparam int COEF_BITS  = 18;   // unsigned Q1.17
   localparam int COEF_FRAC  = 17;
   localparam int GAIN_BITS  = 16;   // signed Q4.12
   localparam int GAIN_FRAC  = 12;
   localparam int POLE_FRAC  = 4;    // extra fraction bits of the pole state
   localparam int POLE_EXTRA = 8;    // pole width over sample width

   // Lowpass sections per cascade
   localparam int STAGES     = 4;
   localparam int STAGE_BITS = $clog2(STAGES);

   // Register file
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_COEF  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_COEF = CSR_INDEX_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PMUL,
      ST_PACC,
      ST_GMUL,
      ST_GACC,
      ST_OUT
   } state_type;

   typedef enum logic {
      CAS_LOW,
      CAS_HIGH
   } cas_type;

   typedef enum logic [1:0] {
      BAND_LOW,
      BAND_MID,
      BAND_HIGH
   } band_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic                  capture;   // latch the input word, clear accumulator
      logic                  mul_en;    // load the product register
      logic                  mul_band;  // 1: band times gain, 0: coef times pole error
      cas_type               cas;
      logic [STAGE_BITS-1:0] stage;
      band_type              band;
      logic                  pole_wr;   // round product into the selected pole
      logic                  acc_en;    // add product into the output accumulator
      logic                  finish;    // load output register, shift delay line
   } ctrl_type;

endpackage

>>> rtl/tbe_if.sv
// Valid/ready channel interfaces of the three-band equalizer.
interface tbe_req_if #(
   parameter int SAMPLE_WIDTH = tbe_pkg::SAMPLE_WIDTH_DEF
);
   logic                                   valid;
   logic                                   ready;
   logic signed [SAMPLE_WIDTH-1:0]         sample_in;
   logic signed [tbe_pkg::GAIN_BITS-1:0]   low_gain;
   logic signed [tbe_pkg::GAIN_BITS-1:0]   mid_gain;
   logic signed [tbe_pkg::GAIN_BITS-1:0]   high_gain;

   modport source (output valid, sample_in, low_gain, mid_gain, high_gain, input ready);
   modport sink   (input valid, sample_in, low_gain, mid_gain, high_gain, output ready);
endinterface

interface tbe_rsp_if #(
   parameter int SAMPLE_WIDTH = tbe_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

interface tbe_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [tbe_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [tbe_pkg::COEF_BITS-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tbe_seq.sv
// Sequencer: steps the shared multiplier through both cascades and the gain sum.
module tbe_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output tbe_pkg::ctrl_type ctrl
);

   localparam logic [tbe_pkg::STAGE_BITS-1:0] STAGE_LAST =
      tbe_pkg::STAGE_BITS'(tbe_pkg::STAGES - 1);

   tbe_pkg::state_type                 state_ff, state_in;
   logic [tbe_pkg::STAGE_BITS-1:0]     stage_ff, stage_in;
   tbe_pkg::cas_type                   cas_ff, cas_in;
   tbe_pkg::band_type                  band_ff, band_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbe_pkg::ST_IDLE;
         stage_ff     <= '0;
         cas_ff       <= tbe_pkg::CAS_LOW;
         band_ff      <= tbe_pkg::BAND_LOW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         cas_ff       <= cas_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and controls
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      cas_in       = cas_ff;
      band_in      = band_ff;
      req_ready    = 1'b0;
      ctrl         = '0;
      ctrl.cas     = cas_ff;
      ctrl.stage   = stage_ff;
      ctrl.band    = band_ff;

      unique case (state_ff)
         tbe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               stage_in     = '0;
               cas_in       = tbe_pkg::CAS_LOW;
               band_in      = tbe_pkg::BAND_LOW;
               state_in     = tbe_pkg::ST_PMUL;
            end
         end
         tbe_pkg::ST_PMUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = tbe_pkg::ST_PACC;
         end
         tbe_pkg::ST_PACC: begin
            ctrl.pole_wr = 1'b1;
            if (stage_ff == STAGE_LAST) begin
               stage_in = '0;
               if (cas_ff == tbe_pkg::CAS_LOW) begin
                  cas_in   = tbe_pkg::CAS_HIGH;
                  state_in = tbe_pkg::ST_PMUL;
               end else begin
                  state_in = tbe_pkg::ST_GMUL;
               end
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = tbe_pkg::ST_PMUL;
            end
         end
         tbe_pkg::ST_GMUL: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_band = 1'b1;
            state_in      = tbe_pkg::ST_GACC;
         end
         tbe_pkg::ST_GACC: begin
            ctrl.acc_en = 1'b1;
            unique case (band_ff)
               tbe_pkg::BAND_LOW: begin
                  band_in  = tbe_pkg::BAND_MID;
                  state_in = tbe_pkg::ST_GMUL;
               end
               tbe_pkg::BAND_MID: begin
                  band_in  = tbe_pkg::BAND_HIGH;
                  state_in = tbe_pkg::ST_GMUL;
               end
               default: begin
                  state_in = tbe_pkg::ST_OUT;
               end
            endcase
         end
         tbe_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.finish = 1'b1;
               state_in    = tbe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbe_pkg::ST_IDLE;
         end
      endcase
   end

   // Output word valid
   always_comb begin
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/tbe_dp.sv
// Datapath: coefficient registers, pole and delay state, shared multiplier, accumulator.
module tbe_dp #(
   parameter int SAMPLE_WIDTH = tbe_pkg::SAMPLE_WIDTH_DEF,
   parameter int DELAY_TAPS   = tbe_pkg::DELAY_TAPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbe_pkg::ctrl_type                     ctrl,
   input  logic                                  csr_we,
   input  logic [tbe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tbe_pkg::COEF_BITS-1:0]         csr_data,
   input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
   input  logic signed [tbe_pkg::GAIN_BITS-1:0]  low_gain,
   input  logic signed [tbe_pkg::GAIN_BITS-1:0]  mid_gain,
   input  logic signed [tbe_pkg::GAIN_BITS-1:0]  high_gain,
   output logic signed [SAMPLE_WIDTH-1:0]        sample_out
);

   localparam int CB   = tbe_pkg::COEF_BITS;
   localparam int GB   = tbe_pkg::GAIN_BITS;
   localparam int PF   = tbe_pkg::POLE_FRAC;
   localparam int NS   = tbe_pkg::STAGES;
   localparam int PW   = SAMPLE_WIDTH + tbe_pkg::POLE_EXTRA;   // pole width
   localparam int DW   = PW + 1;                               // pole error / band width
   localparam int OB   = CB + 1;                               // multiplier B operand
   localparam int PRW  = DW + OB;                              // product width
   localparam int SW1  = PRW + 1;                              // rounded pole sum width
   localparam int AW   = PRW + 2;                              // accumulator width
   localparam int OSH  = tbe_pkg::GAIN_FRAC + PF;              // output shift
   localparam int CSH  = tbe_pkg::COEF_FRAC;                   // pole product shift

   localparam logic signed [SW1-1:0] RND_POLE =
      {{(SW1-CSH){1'b0}}, 1'b1, {(CSH-1){1'b0}}};
   localparam logic signed [SW1-1:0] POLE_MAX =
      {{(SW1-PW+1){1'b0}}, {(PW-1){1'b1}}};
   localparam logic signed [SW1-1:0] POLE_MIN = ~POLE_MAX;
   localparam logic signed [AW-1:0]  RND_OUT =
      {{(AW-OSH){1'b0}}, 1'b1, {(OSH-1){1'b0}}};
   localparam logic signed [AW-1:0]  OUT_MAX =
      {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0]  OUT_MIN = ~OUT_MAX;

   logic [CB-1:0]                  low_coef_ff, low_coef_in;
   logic [CB-1:0]                  high_coef_ff, high_coef_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [GB-1:0]           lg_ff, mg_ff, hg_ff;
   logic signed [PW-1:0]           low_pole_ff [NS];
   logic signed [PW-1:0]           low_pole_in [NS];
   logic signed [PW-1:0]           high_pole_ff [NS];
   logic signed [PW-1:0]           high_pole_in [NS];
   logic signed [SAMPLE_WIDTH-1:0] dly_ff [DELAY_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] dly_in [DELAY_TAPS];
   logic signed [PRW-1:0]          prod_ff, prod_in;
   logic signed [AW-1:0]           acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;

   logic signed [PW-1:0]  xs, dly_s, cur_pole, prev_pole, new_pole;
   logic signed [DW-1:0]  diff, band_l, band_m, band_h, op_a;
   logic signed [OB-1:0]  op_b;
   logic signed [CB-1:0]  coef_sel;
   logic signed [SW1-1:0] prod_rnd, pole_sum;
   logic signed [AW-1:0]  acc_rnd;

   // Samples scaled into pole format
   assign xs    = {{(PW-SAMPLE_WIDTH-PF){x_ff[SAMPLE_WIDTH-1]}}, x_ff, {PF{1'b0}}};
   assign dly_s = {{(PW-SAMPLE_WIDTH-PF){dly_ff[DELAY_TAPS-1][SAMPLE_WIDTH-1]}},
                   dly_ff[DELAY_TAPS-1], {PF{1'b0}}};

   // Pole error of the current section
   always_comb begin
      if (ctrl.cas == tbe_pkg::CAS_HIGH) begin
         cur_pole  = high_pole_ff[ctrl.stage];
         prev_pole = high_pole_ff[ctrl.stage - 1'b1];
         coef_sel  = high_coef_ff;
      end else begin
         cur_pole  = low_pole_ff[ctrl.stage];
         prev_pole = low_pole_ff[ctrl.stage - 1'b1];
         coef_sel  = low_coef_ff;
      end
      if (ctrl.stage == '0) begin
         diff = DW'(xs) - DW'(cur_pole);
      end else begin
         diff = DW'(prev_pole) - DW'(cur_pole);
      end
   end

   // Bands from the last poles; mid = d - (h + l) = high pole - low pole
   assign band_l = DW'(low_pole_ff[NS-1]);
   assign band_h = DW'(dly_s) - DW'(high_pole_ff[NS-1]);
   assign band_m = DW'(high_pole_ff[NS-1]) - DW'(low_pole_ff[NS-1]);

   // Shared multiplier operands
   always_comb begin
      if (ctrl.mul_band) begin
         unique case (ctrl.band)
            tbe_pkg::BAND_LOW: begin
               op_a = band_l;
               op_b = OB'(lg_ff);
            end
            tbe_pkg::BAND_MID: begin
               op_a = band_m;
               op_b = OB'(mg_ff);
            end
            default: begin
               op_a = band_h;
               op_b = OB'(hg_ff);
            end
         endcase
      end else begin
         op_a = diff;
         op_b = signed'({1'b0, coef_sel});
      end
   end

   assign prod_in = ctrl.mul_en ? (PRW'(op_a) * PRW'(op_b)) : prod_ff;

   // Pole update: round to nearest (ties up), add, saturate
   always_comb begin
      prod_rnd = (SW1'(prod_ff) + RND_POLE) >>> CSH;
      pole_sum = SW1'(cur_pole) + prod_rnd;
      if (pole_sum > POLE_MAX) begin
         new_pole = PW'(POLE_MAX);
      end else if (pole_sum < POLE_MIN) begin
         new_pole = PW'(POLE_MIN);
      end else begin
         new_pole = PW'(pole_sum);
      end
   end

   always_comb begin
      low_pole_in  = low_pole_ff;
      high_pole_in = high_pole_ff;
      if (ctrl.pole_wr) begin
         if (ctrl.cas == tbe_pkg::CAS_HIGH) begin
            high_pole_in[ctrl.stage] = new_pole;
         end else begin
            low_pole_in[ctrl.stage] = new_pole;
         end
      end
   end

   // Gain accumulator and output rounding
   always_comb begin
      if (ctrl.capture) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + AW'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      acc_rnd = (acc_ff + RND_OUT) >>> OSH;
      if (!ctrl.finish) begin
         out_in = out_ff;
      end else if (acc_rnd > OUT_MAX) begin
         out_in = SAMPLE_WIDTH'(OUT_MAX);
      end else if (acc_rnd < OUT_MIN) begin
         out_in = SAMPLE_WIDTH'(OUT_MIN);
      end else begin
         out_in = SAMPLE_WIDTH'(acc_rnd);
      end
   end

   // Delay line, newest first
   always_comb begin
      dly_in = dly_ff;
      if (ctrl.finish) begin
         for (int i = DELAY_TAPS - 1; i > 0; i--) begin
            dly_in[i] = dly_ff[i-1];
         end
         dly_in[0] = x_ff;
      end
   end

   // Coefficient registers; other indexes are ignored
   always_comb begin
      low_coef_in  = low_coef_ff;
      high_coef_in = high_coef_ff;
      if (csr_we) begin
         if (csr_index == tbe_pkg::CSR_LOW_COEF) begin
            low_coef_in = csr_data;
         end
         if (csr_index == tbe_pkg::CSR_HIGH_COEF) begin
            high_coef_in = csr_data;
         end
      end
   end

   // Filter state and coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         low_coef_ff  <= '0;
         high_coef_ff <= '0;
         for (int i = 0; i < NS; i++) begin
            low_pole_ff[i]  <= '0;
            high_pole_ff[i] <= '0;
         end
         for (int i = 0; i < DELAY_TAPS; i++) begin
            dly_ff[i] <= '0;
         end
      end else begin
         low_coef_ff  <= low_coef_in;
         high_coef_ff <= high_coef_in;
         low_pole_ff  <= low_pole_in;
         high_pole_ff <= high_pole_in;
         dly_ff       <= dly_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         x_ff  <= sample_in;
         lg_ff <= low_gain;
         mg_ff <= mid_gain;
         hg_ff <= high_gain;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   assign sample_out = out_ff;

endmodule

>>> rtl/three_band_equalizer_unit.sv
// Three-band equalizer: two four-section lowpass cascades and a gain-weighted band sum.
// One shared multiplier is used 8 times for the poles and 3 times for the gains, each use
// having a multiply state and an accumulate state. A new input word is accepted only once
// the previous word has been loaded into the output register.
// The output register holds a finished word while the next input word is accepted.
// Reset (synchronous) clears coefficients, poles and delay line to zero.
module three_band_equalizer_unit #(
   parameter int SAMPLE_WIDTH = tbe_pkg::SAMPLE_WIDTH_DEF,
   parameter int DELAY_TAPS   = tbe_pkg::DELAY_TAPS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   tbe_req_if.sink   req_ch,
   tbe_rsp_if.source rsp_ch,
   tbe_csr_if.sink   csr_ch
);

   tbe_pkg::ctrl_type ctrl;

   // Register writes are taken every cycle
   assign csr_ch.ready = 1'b1;

   tbe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .ctrl      (ctrl)
   );

   tbe_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DELAY_TAPS   (DELAY_TAPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .csr_we     (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .sample_in  (req_ch.sample_in),
      .low_gain   (req_ch.low_gain),
      .mid_gain   (req_ch.mid_gain),
      .high_gain  (req_ch.high_gain),
      .sample_out (rsp_ch.sample_out)
   );

endmodule
